// File: hdl/ilbd_pkg.sv
// shared constants and helpers for the clamped log barrier unit
package ilbd_pkg;

	// fixed-point formats
	localparam int DIST_FRAC_BITS_DEF = 24;
	localparam int OUT_FRAC_BITS      = 24;
	localparam int K_FRAC_BITS        = 16;
	localparam int LOG_FRAC_BITS      = 30;
	localparam int K_SHIFT            = K_FRAC_BITS + LOG_FRAC_BITS - OUT_FRAC_BITS;

	// field widths
	localparam int DIST_W  = 32;
	localparam int WIDTH_W = 31;
	localparam int STIFF_W = 32;
	localparam int RES_W   = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BARRIER_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS     = 2'd1;

	// register reset values
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 31'd1677722;
	localparam logic [STIFF_W-1:0] STIFF_RESET = 32'd65536;

	// ln(2) in Q.28
	localparam logic [27:0] LN2_Q28 = 28'd186065279;

	// saturation limits
	localparam logic [62:0] SAT_CAP = {1'b1, 62'd0};
	localparam logic [RES_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [RES_W-1:0] NEG_MIN = 48'h8000_0000_0000;

	// clamp an intermediate magnitude at 2^62
	function automatic logic [62:0] cap62(logic [127:0] v);
		logic [62:0] r;
		if (v > 128'(SAT_CAP)) begin
			r = SAT_CAP;
		end else begin
			r = v[62:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/ilbd_dist_if.sv
// distance input channel
interface ilbd_dist_if;
	logic valid;
	logic ready;
	logic signed [ilbd_pkg::DIST_W-1:0] distance;

	modport source (output valid, output distance, input ready);
	modport sink (input valid, input distance, output ready);
endinterface

// File: hdl/ilbd_res_if.sv
// barrier result channel
interface ilbd_res_if;
	logic valid;
	logic ready;
	logic signed [ilbd_pkg::RES_W-1:0] energy;
	logic signed [ilbd_pkg::RES_W-1:0] slope;
	logic signed [ilbd_pkg::RES_W-1:0] curvature;
	logic inactive;
	logic blocked;
	logic overflow;

	modport source (output valid, output energy, output slope, output curvature,
		output inactive, output blocked, output overflow, input ready);
	modport sink (input valid, input energy, input slope, input curvature,
		input inactive, input blocked, input overflow, output ready);
endinterface

// File: hdl/ilbd_cfg_if.sv
// configuration write channel
interface ilbd_cfg_if;
	logic valid;
	logic ready;
	logic [ilbd_pkg::CFG_IDX_W-1:0] index;
	logic [ilbd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/ipc_log_barrier_derivatives_unit.sv
// clamped log barrier evaluator: value, slope and curvature per contact distance
//
// Takes one distance per cycle while the result side does not stall and returns energy,
// slope and curvature from a registered pipeline, one result per cycle. The pipeline depth
// is set by the log unit, which resolves one fraction bit of log2 per stage over 30 squaring
// stages, and by the divider for (dh-d)/d, which retires two quotient bits per stage in
// parallel with it; the products after that are split into partial products.
// A stall on the result side freezes the whole pipeline, and the input is not taken
// while it is frozen. Configuration writes are taken at any time and must only be
// issued while no distance is in flight.
module ipc_log_barrier_derivatives_unit #(
	parameter int DIST_FRAC_BITS = ilbd_pkg::DIST_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ilbd_dist_if.sink  item,
	ilbd_res_if.source result,
	ilbd_cfg_if.sink   cfg
);

	localparam int FRONT_LAST = 33;

	typedef struct packed {
		logic [30:0] rem;
		logic [61:0] num;
		logic [61:0] quo;
	} div_t;

	typedef struct packed {
		logic        inact;
		logic        blk;
		logic [30:0] e;
		logic [30:0] ud;
		logic [30:0] dh;
		logic [4:0]  pd;
		logic [4:0]  ph;
		logic [30:0] md;
		logic [30:0] mh;
		logic [29:0] fd;
		logic [29:0] fh;
		div_t        dv;
	} front_t;

	// msb index, zero for zero
	function automatic logic [4:0] msb31(logic [30:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 31; i++) begin
			if (x[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

	// one squaring step: fraction bit on top, new mantissa below
	function automatic logic [31:0] log_step(logic [30:0] m);
		logic [61:0] sq;
		logic [31:0] t;
		logic [31:0] r;
		sq = 62'(m) * 62'(m);
		t = sq[61:30];
		if (t[31]) begin
			r = {1'b1, t[31:1]};
		end else begin
			r = {1'b0, t[30:0]};
		end
		return r;
	endfunction

	// two restoring division steps
	function automatic div_t div_step2(div_t a, logic [30:0] dv);
		div_t r;
		logic [31:0] t;
		r = a;
		for (int i = 0; i < 2; i++) begin
			t = {r.rem, r.num[61]};
			r.num = {r.num[60:0], 1'b0};
			if (t >= {1'b0, dv}) begin
				t = t - {1'b0, dv};
				r.quo = {r.quo[60:0], 1'b1};
			end else begin
				r.quo = {r.quo[60:0], 1'b0};
			end
			r.rem = t[30:0];
		end
		return r;
	endfunction

	logic adv;
	logic [ilbd_pkg::WIDTH_W-1:0] width_q;
	logic [ilbd_pkg::STIFF_W-1:0] stiff_q;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ilbd_pkg::WIDTH_RESET;
			stiff_q <= ilbd_pkg::STIFF_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ilbd_pkg::REG_BARRIER_WIDTH: width_q <= cfg.data[ilbd_pkg::WIDTH_W-1:0];
				ilbd_pkg::REG_STIFFNESS:     stiff_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// global advance, the output register parts the two sides
	logic v_s39;
	assign adv = !v_s39 || result.ready;
	assign item.ready = adv;

	// front: classify, normalize, log and divide
	front_t front_d [1:FRONT_LAST];
	front_t front_s [1:FRONT_LAST];
	logic   vld_s   [1:FRONT_LAST];

	genvar k;
	for (k = 1; k <= FRONT_LAST; k++) begin : g_front
		if (k == 1) begin : g_cls
			always_comb begin
				logic ina;
				ina = $signed(item.distance) >= $signed({1'b0, width_q});
				front_d[k] = '0;
				front_d[k].inact = ina;
				front_d[k].blk = !ina && ($signed(item.distance) <= 32'sd0);
				front_d[k].ud = item.distance[30:0];
				front_d[k].dh = width_q;
				front_d[k].e = width_q - item.distance[30:0];
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv) begin
					vld_s[k] <= item.valid;
				end
			end
		end else begin : g_work
			always_comb begin
				logic [31:0] ld;
				logic [31:0] lh;
				front_d[k] = front_s[k-1];
				// msb search and divider load
				if (k == 2) begin
					front_d[k].pd = msb31(front_s[k-1].ud);
					front_d[k].ph = msb31(front_s[k-1].dh);
					front_d[k].dv.rem = '0;
					front_d[k].dv.quo = '0;
					front_d[k].dv.num = {1'b0, front_s[k-1].e, 30'd0};
				end
				// mantissa alignment
				if (k == 3) begin
					front_d[k].md = 31'(front_s[k-1].ud << (5'd30 - front_s[k-1].pd));
					front_d[k].mh = 31'(front_s[k-1].dh << (5'd30 - front_s[k-1].ph));
				end
				// log2 fraction bit
				if (k >= 4) begin
					ld = log_step(front_s[k-1].md);
					lh = log_step(front_s[k-1].mh);
					front_d[k].md = ld[30:0];
					front_d[k].mh = lh[30:0];
					front_d[k].fd = {front_s[k-1].fd[28:0], ld[31]};
					front_d[k].fh = {front_s[k-1].fh[28:0], lh[31]};
				end
				// quotient bits
				if (k >= 3) begin
					front_d[k].dv = div_step2(front_s[k-1].dv, front_s[k-1].ud);
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				front_s[k] <= front_d[k];
			end
		end
	end

	// stage 34: -ln(d/dh)
	logic v_s34, ina_s34, blk_s34;
	logic [30:0] e_s34;
	logic [60:0] q_s34;
	logic [34:0] nl_s34;
	logic [34:0] lgd, lgh, ldiff;
	logic [62:0] nl_prod;
	assign lgd = {front_s[FRONT_LAST].pd, front_s[FRONT_LAST].fd};
	assign lgh = {front_s[FRONT_LAST].ph, front_s[FRONT_LAST].fh};
	assign ldiff = (lgh > lgd) ? (lgh - lgd) : '0;
	assign nl_prod = 63'(ldiff) * 63'(ilbd_pkg::LN2_Q28);

	// stage 35: partial products
	logic v_s35, ina_s35, blk_s35;
	logic [34:0] nl_s35;
	logic [60:0] q_s35;
	logic [61:0] ee_s35;
	logic [65:0] pa_s35;
	logic [61:0] pql_s35;
	logic [60:0] pqh_s35;
	logic [61:0] qq00_s35;
	logic [60:0] qq01_s35;
	logic [59:0] qq11_s35;

	// stage 36: energy partials, slope and curvature sums
	logic v_s36, ina_s36, blk_s36;
	logic [65:0] enl_s36;
	logic [65:0] enh_s36;
	logic [92:0] ssum_s36;
	logic [92:0] csum_s36;
	logic [91:0] eq_full;
	logic [121:0] qq_full;
	assign eq_full = (92'(pqh_s35) << 31) + 92'(pql_s35);
	assign qq_full = (122'(qq11_s35) << 62) + (122'(qq01_s35) << 32) + 122'(qq00_s35);

	// stage 37: brackets
	logic v_s37, ina_s37, blk_s37;
	logic [62:0] bre_s37, brs_s37, brc_s37;
	logic [96:0] en_full;
	assign en_full = (97'(enh_s36) << 31) + 97'(enl_s36);

	// stage 38: stiffness products
	logic v_s38, ina_s38, blk_s38;
	logic [63:0] kel_s38, ksl_s38, kcl_s38;
	logic [62:0] keh_s38, ksh_s38, kch_s38;

	// stage 39: scale, clip, special cases
	logic ina_s39, blk_s39, ovf_s39;
	logic [ilbd_pkg::RES_W-1:0] en_s39, sl_s39, cu_s39;
	logic [94:0] ke_full, ks_full, kc_full;
	logic [72:0] me, ms, mc;
	logic [47:0] ce, cs, cc;
	logic oe, os, oc;
	assign ke_full = (95'(keh_s38) << 32) + 95'(kel_s38);
	assign ks_full = (95'(ksh_s38) << 32) + 95'(ksl_s38);
	assign kc_full = (95'(kch_s38) << 32) + 95'(kcl_s38);
	assign me = 73'(ke_full >> ilbd_pkg::K_SHIFT);
	assign ms = 73'(ks_full >> ilbd_pkg::K_SHIFT);
	assign mc = 73'(kc_full >> ilbd_pkg::K_SHIFT);
	assign oe = me > 73'(ilbd_pkg::POS_MAX);
	assign oc = mc > 73'(ilbd_pkg::POS_MAX);
	assign os = ms > 73'(ilbd_pkg::NEG_MIN);
	assign ce = oe ? ilbd_pkg::POS_MAX : me[47:0];
	assign cc = oc ? ilbd_pkg::POS_MAX : mc[47:0];
	assign cs = os ? ilbd_pkg::NEG_MIN : 48'(48'd0 - ms[47:0]);

	// valid bits of the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
			v_s36 <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
		end else if (adv) begin
			v_s34 <= vld_s[FRONT_LAST];
			v_s35 <= v_s34;
			v_s36 <= v_s35;
			v_s37 <= v_s36;
			v_s38 <= v_s37;
			v_s39 <= v_s38;
		end
	end

	// back stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ina_s34 <= front_s[FRONT_LAST].inact;
			blk_s34 <= front_s[FRONT_LAST].blk;
			e_s34   <= front_s[FRONT_LAST].e;
			q_s34   <= front_s[FRONT_LAST].dv.quo[60:0];
			nl_s34  <= nl_prod[62:28];

			ina_s35  <= ina_s34;
			blk_s35  <= blk_s34;
			nl_s35   <= nl_s34;
			q_s35    <= q_s34;
			ee_s35   <= 62'(e_s34) * 62'(e_s34);
			pa_s35   <= 66'(e_s34) * 66'(nl_s34);
			pql_s35  <= 62'(e_s34) * 62'(q_s34[30:0]);
			pqh_s35  <= 61'(e_s34) * 61'(q_s34[60:31]);
			qq00_s35 <= 62'(q_s34[30:0]) * 62'(q_s34[30:0]);
			qq01_s35 <= 61'(q_s34[30:0]) * 61'(q_s34[60:31]);
			qq11_s35 <= 60'(q_s34[60:31]) * 60'(q_s34[60:31]);

			ina_s36  <= ina_s35;
			blk_s36  <= blk_s35;
			enl_s36  <= 66'(ee_s35[30:0]) * 66'(nl_s35);
			enh_s36  <= 66'(ee_s35[61:31]) * 66'(nl_s35);
			ssum_s36 <= (93'(pa_s35 >> DIST_FRAC_BITS) << 1) + 93'(eq_full >> DIST_FRAC_BITS);
			csum_s36 <= (93'(nl_s35) << 1) + (93'(q_s35) << 2)
				+ 93'(qq_full >> ilbd_pkg::LOG_FRAC_BITS);

			ina_s37 <= ina_s36;
			blk_s37 <= blk_s36;
			bre_s37 <= ilbd_pkg::cap62(128'(en_full >> (2 * DIST_FRAC_BITS)));
			brs_s37 <= ilbd_pkg::cap62(128'(ssum_s36));
			brc_s37 <= ilbd_pkg::cap62(128'(csum_s36));

			ina_s38 <= ina_s37;
			blk_s38 <= blk_s37;
			kel_s38 <= 64'(bre_s37[31:0]) * 64'(stiff_q);
			keh_s38 <= 63'(bre_s37[62:32]) * 63'(stiff_q);
			ksl_s38 <= 64'(brs_s37[31:0]) * 64'(stiff_q);
			ksh_s38 <= 63'(brs_s37[62:32]) * 63'(stiff_q);
			kcl_s38 <= 64'(brc_s37[31:0]) * 64'(stiff_q);
			kch_s38 <= 63'(brc_s37[62:32]) * 63'(stiff_q);

			ina_s39 <= ina_s38;
			blk_s39 <= blk_s38;
			if (ina_s38) begin
				en_s39  <= '0;
				sl_s39  <= '0;
				cu_s39  <= '0;
				ovf_s39 <= 1'b0;
			end else if (blk_s38) begin
				en_s39  <= ilbd_pkg::POS_MAX;
				sl_s39  <= ilbd_pkg::NEG_MIN;
				cu_s39  <= ilbd_pkg::POS_MAX;
				ovf_s39 <= 1'b0;
			end else begin
				en_s39  <= ce;
				sl_s39  <= cs;
				cu_s39  <= cc;
				ovf_s39 <= oe || os || oc;
			end
		end
	end

	// result channel
	assign result.valid     = v_s39;
	assign result.energy    = en_s39;
	assign result.slope     = sl_s39;
	assign result.curvature = cu_s39;
	assign result.inactive  = ina_s39;
	assign result.blocked   = blk_s39;
	assign result.overflow  = ovf_s39;

endmodule

// File: hdl/ilbd_checker.sv
// port-level checks for the clamped log barrier unit, bound to the top level
module ilbd_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic signed [ilbd_pkg::RES_W-1:0] energy,
	input logic signed [ilbd_pkg::RES_W-1:0] slope,
	input logic signed [ilbd_pkg::RES_W-1:0] curvature,
	input logic inactive,
	input logic blocked,
	input logic overflow
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(energy) && $stable(slope)
			&& $stable(curvature) && $stable(overflow))
		else $error("result changed while stalled");

	// inactive distance gives zeros
	a_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && inactive |-> !blocked && !overflow && energy == '0 && slope == '0
			&& curvature == '0)
		else $error("inactive result not zero");

	// blocked distance gives saturated values
	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && blocked |-> !overflow && energy == ilbd_pkg::POS_MAX
			&& slope == ilbd_pkg::NEG_MIN && curvature == ilbd_pkg::POS_MAX)
		else $error("blocked result not saturated");

	// signs of an active result
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !inactive && !blocked |-> !energy[47] && !curvature[47]
			&& (slope[47] || slope == '0))
		else $error("active result has wrong sign");

endmodule

bind ipc_log_barrier_derivatives_unit ilbd_checker u_ilbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.energy    (result.energy),
	.slope     (result.slope),
	.curvature (result.curvature),
	.inactive  (result.inactive),
	.blocked   (result.blocked),
	.overflow  (result.overflow)
);

// File: sim/tb_ilbd_pkg_note.sv
// testbench-side constants for the clamped log barrier unit checks
`timescale 1ns / 100ps
package tb_ilbd_const_pkg;
	localparam int TB_CLK_HALF   = 10;
	localparam int TB_RST_CYCLES = 7;
	localparam int TB_LATENCY    = 39;
	localparam int TB_MAX_GAP    = 16;
endpackage

// File: sim/tb_top.sv
// self-checking testbench for the clamped log barrier unit
`timescale 1ns / 100ps
module tb_top;

	localparam int DIST_W = ilbd_pkg::DIST_W;
	localparam int RES_W  = ilbd_pkg::RES_W;

	typedef struct packed {
		logic [RES_W-1:0] energy;
		logic [RES_W-1:0] slope;
		logic [RES_W-1:0] curvature;
		logic inactive;
		logic blocked;
		logic overflow;
	} barrier_res_t;

	localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;

	logic clk;
	logic arst_n;
	int   cycle_cnt;
	int   err_cnt;

	ilbd_dist_if dist_ch ();
	ilbd_res_if  res_ch ();
	ilbd_cfg_if  cfg_ch ();

	ipc_log_barrier_derivatives_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (dist_ch.sink),
		.result (res_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// predictor copy of the registers
	logic [63:0] pred_width;
	logic [63:0] pred_stiff;
	barrier_res_t expected_q[$];

	// clock
	initial clk = 1'b0;
	always #(tb_ilbd_const_pkg::TB_CLK_HALF) clk = ~clk;

	// floor(a*b / 2^s) saturated at 2^62
	function automatic logic [63:0] mul_cap(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = (128'(a) * 128'(b)) >> s;
		return (p > 128'(CAP)) ? CAP : p[63:0];
	endfunction

	function automatic logic [63:0] add_cap(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		return (r > CAP) ? CAP : r;
	endfunction

	// binary log in Q.30 by msb search and repeated squaring
	function automatic logic [63:0] log2_fix(logic [63:0] x);
		int p;
		logic [63:0] m;
		logic [63:0] frac;
		p = 0;
		frac = 0;
		while (p < 30 && (x >> (p + 1)) != 0) p++;
		m = x << (30 - p);
		for (int i = 0; i < ilbd_pkg::LOG_FRAC_BITS; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(p) << ilbd_pkg::LOG_FRAC_BITS) | frac;
	endfunction

	// bracket times stiffness, clipped to the result range
	function automatic logic [RES_W-1:0] scale_clip(logic [63:0] br, bit neg, ref bit ovf);
		logic [63:0] mag;
		mag = mul_cap(br, pred_stiff, ilbd_pkg::K_SHIFT);
		if (neg) begin
			if (mag > 64'h8000_0000_0000) begin
				mag = 64'h8000_0000_0000;
				ovf = 1'b1;
			end
			return RES_W'(64'd0 - mag);
		end
		if (mag > 64'h7FFF_FFFF_FFFF) begin
			mag = 64'h7FFF_FFFF_FFFF;
			ovf = 1'b1;
		end
		return mag[RES_W-1:0];
	endfunction

	function automatic barrier_res_t predict_barrier(logic signed [DIST_W-1:0] dist_val);
		barrier_res_t r;
		longint d;
		logic [63:0] e, lgd, lgh, nl, q, t;
		bit ovf;
		r = '0;
		ovf = 1'b0;
		d = longint'(dist_val);
		if (d >= longint'(pred_width)) begin
			r.inactive = 1'b1;
			return r;
		end
		if (d <= 0) begin
			r.energy = ilbd_pkg::POS_MAX;
			r.slope = ilbd_pkg::NEG_MIN;
			r.curvature = ilbd_pkg::POS_MAX;
			r.blocked = 1'b1;
			return r;
		end
		e = pred_width - 64'(d);
		lgd = log2_fix(64'(d));
		lgh = log2_fix(pred_width);
		nl = (lgh > lgd) ? (((lgh - lgd) * 64'(ilbd_pkg::LN2_Q28)) >> 28) : 64'd0;
		q = (e << ilbd_pkg::LOG_FRAC_BITS) / 64'(d);
		t = mul_cap(e * e, nl, 2 * ilbd_pkg::DIST_FRAC_BITS_DEF);
		r.energy = scale_clip(t, 1'b0, ovf);
		t = mul_cap(e, nl, ilbd_pkg::DIST_FRAC_BITS_DEF);
		t = add_cap(t, t);
		t = add_cap(t, mul_cap(e, q, ilbd_pkg::DIST_FRAC_BITS_DEF));
		r.slope = scale_clip(t, 1'b1, ovf);
		t = add_cap(nl, nl);
		t = add_cap(t, mul_cap(q, 4, 0));
		t = add_cap(t, mul_cap(q, q, ilbd_pkg::LOG_FRAC_BITS));
		r.curvature = scale_clip(t, 1'b0, ovf);
		r.overflow = ovf;
		return r;
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 400000) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// result side: random stalls and checking
	int stall_left;
	initial begin
		stall_left = 0;
		res_ch.ready = 1'b0;
	end
	always @(posedge clk) begin
		barrier_res_t got, exp_r;
		int wait_draw;
		if (res_ch.valid && res_ch.ready) begin
			got = '{res_ch.energy, res_ch.slope, res_ch.curvature,
				res_ch.inactive, res_ch.blocked, res_ch.overflow};
			if (expected_q.size() == 0) begin
				err_cnt = err_cnt + 1;
				if (err_cnt <= 10) $display("unexpected result transfer %p", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got !== exp_r) begin
					err_cnt = err_cnt + 1;
					if (err_cnt <= 10)
						$display("mismatch: expected %p actual %p", exp_r, got);
				end
			end
		end
		// fresh stall drawn per result, with quiet stretches
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (res_ch.ready && res_ch.valid || !res_ch.ready) begin
			wait_draw = ((cycle_cnt / 2000) % 3 == 0) ? 0
				: $urandom_range(0, tb_ilbd_const_pkg::TB_MAX_GAP);
			if (!res_ch.ready || wait_draw == 0) begin
				res_ch.ready <= 1'b1;
			end else begin
				stall_left <= wait_draw - 1;
				res_ch.ready <= 1'b0;
			end
		end
	end

	// one distance transfer, with an optional random gap before it
	task automatic send_distance(logic signed [DIST_W-1:0] dist_val, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, tb_ilbd_const_pkg::TB_MAX_GAP) : 0;
		if (gaps && ($urandom_range(0, 3) == 0)) gap = 0;
		if (gap > 0) begin
			dist_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		dist_ch.valid <= 1'b1;
		dist_ch.distance <= dist_val;
		expected_q.push_back(predict_barrier(dist_val));
		do @(posedge clk); while (!dist_ch.ready);
	endtask

	// wait for all results, then for the pipeline to drain
	task automatic wait_idle();
		dist_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (tb_ilbd_const_pkg::TB_LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(logic [ilbd_pkg::CFG_IDX_W-1:0] idx,
		logic [ilbd_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == ilbd_pkg::REG_BARRIER_WIDTH) pred_width = 64'(val[ilbd_pkg::WIDTH_W-1:0]);
		else if (idx == ilbd_pkg::REG_STIFFNESS) pred_stiff = 64'(val);
		@(posedge clk);
	endtask

	// random distance, biased inside the active band
	function automatic logic signed [DIST_W-1:0] rand_distance();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6 && pred_width > 1)
			return DIST_W'($urandom_range(1, 32'(pred_width - 1)));
		if (sel < 8) return DIST_W'($urandom());
		return DIST_W'(longint'(pred_width) + $urandom_range(0, 3) - 2);
	endfunction

	// extremes, special cases, reset register values
	task automatic test_directed();
		send_distance(32'sh8000_0000, 1'b0);
		send_distance(32'sh7FFF_FFFF, 1'b0);
		send_distance(32'sd0, 1'b0);
		send_distance(-32'sd1, 1'b0);
		send_distance(32'sd1, 1'b0);
		send_distance(32'sd2, 1'b0);
		send_distance(DIST_W'(pred_width), 1'b0);
		send_distance(DIST_W'(pred_width - 1), 1'b0);
		send_distance(DIST_W'(pred_width + 1), 1'b0);
		send_distance(DIST_W'(pred_width / 2), 1'b0);
		send_distance(32'sh0100_0000, 1'b0);
		send_distance(32'sh5555_5555, 1'b0);
		send_distance(32'shAAAA_AAAA, 1'b0);
		wait_idle();
	endtask

	// register extremes including zero width and zero stiffness
	task automatic test_register_extremes();
		write_reg(ilbd_pkg::REG_BARRIER_WIDTH, 32'h7FFF_FFFF);
		write_reg(ilbd_pkg::REG_STIFFNESS, 32'hFFFF_FFFF);
		send_distance(32'sd1, 1'b0);
		send_distance(32'sh4000_0000, 1'b0);
		send_distance(32'sh7FFF_FFFE, 1'b0);
		send_distance(32'sh7FFF_FFFF, 1'b0);
		wait_idle();
		write_reg(ilbd_pkg::REG_BARRIER_WIDTH, 32'd0);
		write_reg(ilbd_pkg::REG_STIFFNESS, 32'd0);
		send_distance(32'sd0, 1'b0);
		send_distance(-32'sd5, 1'b0);
		send_distance(32'sd5, 1'b0);
		wait_idle();
		write_reg(ilbd_pkg::REG_BARRIER_WIDTH, 32'd1);
		send_distance(32'sd0, 1'b0);
		send_distance(32'sd1, 1'b0);
		wait_idle();
	endtask

	// random distances under several register settings
	task automatic test_random_stream();
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin
					write_reg(ilbd_pkg::REG_BARRIER_WIDTH, 32'(ilbd_pkg::WIDTH_RESET));
					write_reg(ilbd_pkg::REG_STIFFNESS, 32'(ilbd_pkg::STIFF_RESET));
				end
				6: begin
					write_reg(ilbd_pkg::REG_BARRIER_WIDTH, 32'h7FFF_FFFF);
					write_reg(ilbd_pkg::REG_STIFFNESS, 32'hFFFF_FFFF);
				end
				default: begin
					write_reg(ilbd_pkg::REG_BARRIER_WIDTH, $urandom_range(1, 32'h7FFF_FFFF));
					write_reg(ilbd_pkg::REG_STIFFNESS, $urandom());
				end
			endcase
			for (int n = 0; n < 100; n++) begin
				send_distance(rand_distance(), (phase % 2) == 0 || n > 50);
				// sender holds off until everything has come back
				if (n == 30) begin
					dist_ch.valid <= 1'b0;
					@(posedge clk);
					while (expected_q.size() != 0) @(posedge clk);
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		cycle_cnt = 0;
		err_cnt = 0;
		pred_width = 64'(ilbd_pkg::WIDTH_RESET);
		pred_stiff = 64'(ilbd_pkg::STIFF_RESET);
		arst_n = 1'b0;
		dist_ch.valid = 1'b0;
		dist_ch.distance = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ilbd_pkg::REG_BARRIER_WIDTH;
		cfg_ch.data = '0;
		repeat (tb_ilbd_const_pkg::TB_RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_stream();
		if (err_cnt == 0 && expected_q.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
